// ===== hdl/arc_event_detector_macros.svh =====
// ----------------------------------------------------------------------------
// arc_event_detector_macros
// assertion shorthands shared by the arc event detector modules
// ----------------------------------------------------------------------------
`ifndef ARC_EVENT_DETECTOR_MACROS_SVH
`define ARC_EVENT_DETECTOR_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define AED_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define AED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/aed_pkg.sv =====
// ----------------------------------------------------------------------------
// aed_pkg
// widths, register codes and shared types of the arc event detector
// ----------------------------------------------------------------------------
`default_nettype none

package aed_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COUNT_BITS     = 16;
    localparam int THR_BITS       = 15;
    localparam int TIMEOUT_BITS   = 16;
    localparam int TIME_BITS      = 32;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;

    // compare width: room for sign, sample difference and doubling
    localparam int CMP_BITS = ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + 2;

    localparam logic [THR_BITS-1:0]     THR_RESET     = '0;
    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(100);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ARC_THRESHOLD = CFG_INDEX_BITS'(0),
        REG_EVENT_TIMEOUT = CFG_INDEX_BITS'(1)
    } t_cfg_reg;

    typedef struct packed {
        logic is_arc;
        logic is_pulse;
    } t_class;

    typedef struct packed {
        logic                  emit;
        logic [COUNT_BITS-1:0] arc_samples;
        logic [COUNT_BITS-1:0] pulse_samples;
        logic [TIME_BITS-1:0]  duration_ms;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/aed_classify.sv =====
// ----------------------------------------------------------------------------
// aed_classify
// arc and pulse classification of one sample against the threshold and the stored sample
// ----------------------------------------------------------------------------
`default_nettype none

module aed_classify import aed_pkg::*; (
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_prev_sample,
    input  logic        [THR_BITS-1:0]    i_threshold,
    output t_class                        o_class
);

    logic signed [CMP_BITS-1:0] w_s;
    logic signed [CMP_BITS-1:0] w_p;
    logic signed [CMP_BITS-1:0] w_thr;
    logic signed [CMP_BITS-1:0] w_delta;
    logic        [CMP_BITS-1:0] w_abs;
    logic        [CMP_BITS-1:0] w_dbl;

    assign w_s     = CMP_BITS'(i_sample);
    assign w_p     = CMP_BITS'(i_prev_sample);
    assign w_thr   = $signed(CMP_BITS'(i_threshold));
    assign w_delta = w_s - w_p;
    assign w_abs   = w_delta[CMP_BITS-1] ? unsigned'(-w_delta) : unsigned'(w_delta);
    // 2*|delta| > threshold, exact in integers
    assign w_dbl   = {w_abs[CMP_BITS-2:0], 1'b0};

    assign o_class.is_arc   = (w_s > w_thr);
    assign o_class.is_pulse = (w_dbl > unsigned'(w_thr));

endmodule

`default_nettype wire

// ===== hdl/aed_event.sv =====
// ----------------------------------------------------------------------------
// aed_event
// event state: priming, open/close decision, saturating counters
// ----------------------------------------------------------------------------
`default_nettype none

`include "arc_event_detector_macros.svh"

module aed_event import aed_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic        [TIME_BITS-1:0]   i_time_ms,
    input  logic        [TIMEOUT_BITS-1:0] i_timeout_ms,
    input  t_class                        i_class,
    output logic signed [SAMPLE_BITS-1:0] o_prev_sample,
    output t_result                       o_result
);

    logic                          r_primed,    n_primed;
    logic signed [SAMPLE_BITS-1:0] r_prev,      n_prev;
    logic                          r_open,      n_open;
    logic        [TIME_BITS-1:0]   r_start_ms,  n_start_ms;
    logic        [COUNT_BITS-1:0]  r_arc_cnt,   n_arc_cnt;
    logic        [COUNT_BITS-1:0]  r_pulse_cnt, n_pulse_cnt;

    logic [TIME_BITS-1:0]  w_elapsed;
    logic [COUNT_BITS-1:0] w_pulse_upd;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + COUNT_BITS'(1);
    endfunction

    assign w_elapsed   = i_time_ms - r_start_ms;
    assign w_pulse_upd = i_class.is_pulse ? sat_inc(r_pulse_cnt) : r_pulse_cnt;

    always_comb begin
        n_primed    = r_primed;
        n_prev      = r_prev;
        n_open      = r_open;
        n_start_ms  = r_start_ms;
        n_arc_cnt   = r_arc_cnt;
        n_pulse_cnt = r_pulse_cnt;

        o_result.emit          = 1'b0;
        o_result.arc_samples   = r_arc_cnt;
        o_result.pulse_samples = w_pulse_upd;
        o_result.duration_ms   = w_elapsed;

        if (!r_primed) begin
            n_primed = 1'b1;
            n_prev   = i_sample;
        end else begin
            n_prev = i_sample;
            if (i_class.is_arc) begin
                if (!r_open) begin
                    n_open      = 1'b1;
                    n_start_ms  = i_time_ms;
                    n_arc_cnt   = COUNT_BITS'(1);
                    n_pulse_cnt = i_class.is_pulse ? COUNT_BITS'(1) : '0;
                end else begin
                    n_arc_cnt   = sat_inc(r_arc_cnt);
                    n_pulse_cnt = w_pulse_upd;
                end
            end else if (r_open) begin
                n_pulse_cnt = w_pulse_upd;
                if (w_elapsed > TIME_BITS'(i_timeout_ms)) begin
                    o_result.emit = 1'b1;
                    n_open        = 1'b0;
                    n_arc_cnt     = '0;
                    n_pulse_cnt   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed    <= 1'b0;
            r_prev      <= '0;
            r_open      <= 1'b0;
            r_start_ms  <= '0;
            r_arc_cnt   <= '0;
            r_pulse_cnt <= '0;
        end else if (i_take) begin
            r_primed    <= n_primed;
            r_prev      <= n_prev;
            r_open      <= n_open;
            r_start_ms  <= n_start_ms;
            r_arc_cnt   <= n_arc_cnt;
            r_pulse_cnt <= n_pulse_cnt;
        end
    end

    assign o_prev_sample = r_prev;

    `AED_ASSERT_NOW(a_emit_needs_open, i_clk, i_rst_n, o_result.emit, r_open && r_primed, "close without an open event")
    `AED_ASSERT_NOW(a_open_has_arc, i_clk, i_rst_n, r_open, r_arc_cnt != '0, "open event with zero arc count")
    `AED_ASSERT_NEXT(a_close_clears, i_clk, i_rst_n, i_take && o_result.emit, !r_open && r_arc_cnt == '0 && r_pulse_cnt == '0, "counters not cleared at close")

endmodule

`default_nettype wire

// ===== hdl/arc_event_detector.sv =====
// ----------------------------------------------------------------------------
// arc_event_detector
// flags arc and pulse samples, groups them into events, reports closed events
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   ------------------------------------------
//  in        i_valid / o_ready    i_sample, i_time_ms
//  out       o_valid / i_ready    o_arc_samples, o_pulse_samples, o_duration_ms
//  config    i_cfg_we             i_cfg_index, i_cfg_data
//
//  one request per cycle unless the output register stalls, the only hold-up:
//  an accepted sample is held in the input register, the classifier and event
//  logic work on the held sample, and a closed event lands in the output
//  register when the sample is taken; a stalled result keeps the input
//  register full, so o_ready drops only while both registers are occupied
//  synchronous active-low reset clears control state and loads the register
//  defaults (threshold 0, timeout 100 ms)
// ----------------------------------------------------------------------------
`default_nettype none

`include "arc_event_detector_macros.svh"

module arc_event_detector import aed_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample requests
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample,
    input  logic        [TIME_BITS-1:0]    i_time_ms,
    // closed event reports
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic        [COUNT_BITS-1:0]   o_arc_samples,
    output logic        [COUNT_BITS-1:0]   o_pulse_samples,
    output logic        [TIME_BITS-1:0]    o_duration_ms,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic        [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic        [CFG_DATA_BITS-1:0]  i_cfg_data
);

    // configuration registers
    logic [THR_BITS-1:0]     r_arc_threshold;
    logic [TIMEOUT_BITS-1:0] r_event_timeout_ms;

    // input register
    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_sample;
    logic        [TIME_BITS-1:0]   r_in_time_ms;

    // output register
    logic                  r_out_valid;
    logic [COUNT_BITS-1:0] r_out_arc;
    logic [COUNT_BITS-1:0] r_out_pulse;
    logic [TIME_BITS-1:0]  r_out_duration;

    logic                          w_take;
    logic                          w_in_acc;
    logic signed [SAMPLE_BITS-1:0] w_prev_sample;
    t_class                        w_class;
    t_result                       w_res;

    // the held request is processed once the output register has room
    assign w_take   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready  = !r_in_valid || w_take;
    assign w_in_acc = i_valid && o_ready;

    // register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arc_threshold    <= THR_RESET;
            r_event_timeout_ms <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ARC_THRESHOLD: r_arc_threshold    <= i_cfg_data[THR_BITS-1:0];
                REG_EVENT_TIMEOUT: r_event_timeout_ms <= i_cfg_data[TIMEOUT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_sample  <= i_sample;
            r_in_time_ms <= i_time_ms;
        end
    end

    aed_classify u_classify (
        .i_sample      (r_in_sample),
        .i_prev_sample (w_prev_sample),
        .i_threshold   (r_arc_threshold),
        .o_class       (w_class)
    );

    aed_event u_event (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (w_take),
        .i_sample      (r_in_sample),
        .i_time_ms     (r_in_time_ms),
        .i_timeout_ms  (r_event_timeout_ms),
        .i_class       (w_class),
        .o_prev_sample (w_prev_sample),
        .o_result      (w_res)
    );

    // output register: loads on a closing sample, empties when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take && w_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_res.emit) begin
            r_out_arc      <= w_res.arc_samples;
            r_out_pulse    <= w_res.pulse_samples;
            r_out_duration <= w_res.duration_ms;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_arc_samples   = r_out_arc;
    assign o_pulse_samples = r_out_pulse;
    assign o_duration_ms   = r_out_duration;

    `AED_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && !w_take, r_in_valid && $stable(r_in_sample) && $stable(r_in_time_ms), "held sample lost")
    `AED_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !r_in_valid, o_ready, "empty input register not ready")
    `AED_ASSERT_NOW(a_result_from_close, i_clk, i_rst_n, $rose(r_out_valid), $past(w_take && w_res.emit), "result without a closing sample")

endmodule

`default_nettype wire
